### sv/afrl_pkg.sv
// types and constants shared by the failure rate limiter modules
package afrl_pkg;

	localparam int KEY_W  = 32;
	localparam int TIME_W = 63;
	localparam int CNT_W  = 8;
	localparam int CFG_W  = 32;

	typedef logic [TIME_W-1:0] time_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [KEY_W-1:0]  key_t;

	localparam time_t TIME_MAX = '1;
	localparam cnt_t  CNT_MAX  = '1;

	localparam logic [1:0] MODE_FAIL    = 2'd1;
	localparam logic [1:0] MODE_SUCCESS = 2'd2;

	localparam logic [1:0] REG_MAX_FAILS = 2'd0;
	localparam logic [1:0] REG_WINDOW_US = 2'd1;
	localparam logic [1:0] REG_BLOCK_US  = 2'd2;

	localparam logic [7:0]  MAX_FAILS_RST = 8'd5;
	localparam logic [31:0] WINDOW_US_RST = 32'd60000000;
	localparam logic [31:0] BLOCK_US_RST  = 32'd60000000;

	// search record handed from cell to cell
	typedef struct packed {
		logic  found;
		time_t f_ws;
		cnt_t  f_cnt;
		time_t f_be;
		logic  have_empty;
		logic  have_oldest;
		time_t old_ws;
	} scan_t;

	// entry write broadcast to all cells
	typedef struct packed {
		logic  en;
		key_t  key;
		time_t ws;
		cnt_t  cnt;
		time_t be;
	} wr_t;

endpackage

### sv/afrl_cell.sv
// one table entry plus one stage of the lookup chain
module afrl_cell #(
	parameter int ENTRIES  = 16,
	parameter int CELL_IDX = 0
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  afrl_pkg::key_t               key,
	input  logic                         in_valid,
	input  afrl_pkg::scan_t              in_rec,
	input  logic [$clog2(ENTRIES)-1:0]   in_found_idx,
	input  logic [$clog2(ENTRIES)-1:0]   in_empty_idx,
	input  logic [$clog2(ENTRIES)-1:0]   in_old_idx,
	output logic                         out_valid,
	output afrl_pkg::scan_t              out_rec,
	output logic [$clog2(ENTRIES)-1:0]   out_found_idx,
	output logic [$clog2(ENTRIES)-1:0]   out_empty_idx,
	output logic [$clog2(ENTRIES)-1:0]   out_old_idx,
	input  afrl_pkg::wr_t                wr,
	input  logic [$clog2(ENTRIES)-1:0]   wr_idx
);
	import afrl_pkg::*;

	localparam int IDX_W = $clog2(ENTRIES);
	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

	key_t  key_q;
	time_t ws_q;
	cnt_t  cnt_q;
	time_t be_q;

	scan_t            rec;
	logic [IDX_W-1:0] found_idx;
	logic [IDX_W-1:0] empty_idx;
	logic [IDX_W-1:0] old_idx;

	always_comb begin
		rec       = in_rec;
		found_idx = in_found_idx;
		empty_idx = in_empty_idx;
		old_idx   = in_old_idx;
		if (!in_rec.found) begin
			if (key_q == key) begin
				rec.found = 1'b1;
				rec.f_ws  = ws_q;
				rec.f_cnt = cnt_q;
				rec.f_be  = be_q;
				found_idx = MY_IDX;
			end else begin
				if (key_q == '0 && !in_rec.have_empty) begin
					rec.have_empty = 1'b1;
					empty_idx      = MY_IDX;
				end
				if (!in_rec.have_oldest || ws_q < in_rec.old_ws) begin
					rec.have_oldest = 1'b1;
					rec.old_ws      = ws_q;
					old_idx         = MY_IDX;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			key_q     <= '0;
			ws_q      <= '0;
			cnt_q     <= '0;
			be_q      <= '0;
		end else begin
			out_valid <= in_valid;
			if (wr.en && wr_idx == MY_IDX) begin
				key_q <= wr.key;
				ws_q  <= wr.ws;
				cnt_q <= wr.cnt;
				be_q  <= wr.be;
			end
		end
	end

	always_ff @(posedge clk) begin
		out_rec       <= rec;
		out_found_idx <= found_idx;
		out_empty_idx <= empty_idx;
		out_old_idx   <= old_idx;
	end

endmodule

### sv/afrl_ctrl.sv
// sequencer: starts the lookup, updates the entry and holds the result beat
module afrl_ctrl #(
	parameter int ENTRIES = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [1:0]                   mode,
	input  afrl_pkg::key_t               addr,
	input  afrl_pkg::time_t              now,
	input  logic [7:0]                   max_fails,
	input  logic [31:0]                  window_us,
	input  logic [31:0]                  block_us,
	output logic                         scan_start,
	output afrl_pkg::key_t               scan_key,
	input  logic                         scan_done,
	input  afrl_pkg::scan_t              scan_rec,
	input  logic [$clog2(ENTRIES)-1:0]   found_idx,
	input  logic [$clog2(ENTRIES)-1:0]   empty_idx,
	input  logic [$clog2(ENTRIES)-1:0]   old_idx,
	output afrl_pkg::wr_t                wr,
	output logic [$clog2(ENTRIES)-1:0]   wr_idx,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic                         blocked,
	output logic                         block_started,
	output afrl_pkg::cnt_t               fails_in_window,
	output logic [$clog2(ENTRIES)-1:0]   slot_used
);
	import afrl_pkg::*;

	localparam int IDX_W = $clog2(ENTRIES);

	typedef enum logic [2:0] {ST_IDLE, ST_SCAN, ST_DIFF, ST_UPD, ST_OUT} state_t;

	state_t           state_q;
	logic             start_q;
	logic [1:0]       mode_q;
	key_t             addr_q;
	time_t            now_q;
	logic [IDX_W-1:0] slot_q;
	time_t            ws_q;
	cnt_t             cnt_q;
	time_t            be_q;
	logic             started_q;
	logic [63:0]      diff_q;
	logic [63:0]      sum_q;
	wr_t              wr_q;
	logic             m_tvalid_q;
	logic             blocked_q;
	logic             block_started_q;
	cnt_t             fails_q;
	logic [IDX_W-1:0] slot_out_q;

	logic  restart;
	cnt_t  cnt_a;
	cnt_t  cnt_b;
	logic  hit;
	time_t end_t;
	time_t ws_n;
	cnt_t  cnt_n;
	time_t be_n;
	logic  started_n;

	always_comb begin
		restart   = $signed(diff_q) > $signed({32'b0, window_us});
		cnt_a     = restart ? '0 : cnt_q;
		cnt_b     = (cnt_a != CNT_MAX) ? cnt_a + 1'b1 : cnt_a;
		hit       = cnt_b >= max_fails;
		end_t     = sum_q[63] ? TIME_MAX : sum_q[62:0];
		ws_n      = ws_q;
		cnt_n     = cnt_q;
		be_n      = be_q;
		started_n = 1'b0;
		if (mode_q == MODE_FAIL) begin
			ws_n      = restart ? now_q : ws_q;
			cnt_n     = cnt_b;
			be_n      = hit ? end_t : be_q;
			started_n = hit;
		end else if (mode_q == MODE_SUCCESS) begin
			cnt_n = '0;
			be_n  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			start_q         <= 1'b0;
			mode_q          <= '0;
			addr_q          <= '0;
			now_q           <= '0;
			slot_q          <= '0;
			ws_q            <= '0;
			cnt_q           <= '0;
			be_q            <= '0;
			started_q       <= 1'b0;
			diff_q          <= '0;
			sum_q           <= '0;
			wr_q            <= '0;
			m_tvalid_q      <= 1'b0;
			blocked_q       <= 1'b0;
			block_started_q <= 1'b0;
			fails_q         <= '0;
			slot_out_q      <= '0;
		end else begin
			start_q <= (state_q == ST_IDLE) && s_tvalid;
			wr_q.en <= (state_q == ST_UPD);
			if (state_q == ST_OUT && (!m_tvalid_q || m_tready))
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						mode_q  <= mode;
						addr_q  <= addr;
						now_q   <= now;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (scan_done) begin
						if (scan_rec.found) begin
							slot_q <= found_idx;
							ws_q   <= scan_rec.f_ws;
							cnt_q  <= scan_rec.f_cnt;
							be_q   <= scan_rec.f_be;
						end else begin
							slot_q <= scan_rec.have_empty ? empty_idx : old_idx;
							ws_q   <= now_q;
							cnt_q  <= '0;
							be_q   <= '0;
						end
						state_q <= ST_DIFF;
					end
				end
				ST_DIFF: begin
					diff_q  <= {1'b0, now_q} - {1'b0, ws_q};
					sum_q   <= {1'b0, now_q} + {32'b0, block_us};
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					wr_q.key  <= addr_q;
					wr_q.ws   <= ws_n;
					wr_q.cnt  <= cnt_n;
					wr_q.be   <= be_n;
					cnt_q     <= cnt_n;
					be_q      <= be_n;
					started_q <= started_n;
					state_q   <= ST_OUT;
				end
				ST_OUT: begin
					if (!m_tvalid_q || m_tready) begin
						blocked_q       <= be_q > now_q;
						block_started_q <= started_q;
						fails_q         <= cnt_q;
						slot_out_q      <= slot_q;
						state_q         <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign s_tready        = (state_q == ST_IDLE);
	assign scan_start      = start_q;
	assign scan_key        = addr_q;
	assign wr              = wr_q;
	assign wr_idx          = slot_q;
	assign m_tvalid        = m_tvalid_q;
	assign blocked         = blocked_q;
	assign block_started   = block_started_q;
	assign fails_in_window = fails_q;
	assign slot_used       = slot_out_q;

endmodule

### sv/auth_fail_rate_limiter_core.sv
// top level of the per-source authentication failure rate limiter
//
// input beats on s_*: s_tuser carries mode (0 check, 1 failure, 2 success,
// 3 acts as check), s_tdata carries source_address and now_us
// result beats on m_*: one result beat per input beat, in order
// configuration over the apb port: max_fails at 0x0, window_us at 0x4,
// block_us at 0x8; the user writes them only while no beat is in flight, which the block does not enforce
// the table is a row of ENTRIES cells; a lookup walks the row one cell a
// cycle, and the next item is taken once the previous result is registered
// s_tready is high only between items
// reset clears the whole table and loads the register defaults at once
// a stalled m_tready holds the result beat; one more item may be accepted
// and waits at its final step until the held beat leaves
module auth_fail_rate_limiter_core #(
	parameter int ENTRIES = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [95:0]  s_tdata,   // source_address[31:0], now_us[94:32], zero[95]
	input  logic [1:0]   s_tuser,   // mode[1:0]
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [15:0]  m_tdata,   // blocked[0], block_started[1], fails_in_window[9:2],
	                                // slot_used[13:10], zero[15:14]
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [3:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);
	import afrl_pkg::*;

	localparam int IDX_W = $clog2(ENTRIES);

	logic [7:0]  max_fails_q;
	logic [31:0] window_us_q;
	logic [31:0] block_us_q;

	logic             chain_valid [ENTRIES+1];
	scan_t            chain_rec   [ENTRIES+1];
	logic [IDX_W-1:0] chain_found [ENTRIES+1];
	logic [IDX_W-1:0] chain_empty [ENTRIES+1];
	logic [IDX_W-1:0] chain_old   [ENTRIES+1];

	logic             scan_start;
	key_t             scan_key;
	wr_t              wr;
	logic [IDX_W-1:0] wr_idx;
	logic             blocked;
	logic             block_started;
	cnt_t             fails_in_window;
	logic [IDX_W-1:0] slot_used;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_fails_q <= MAX_FAILS_RST;
			window_us_q <= WINDOW_US_RST;
			block_us_q  <= BLOCK_US_RST;
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[3:2])
				REG_MAX_FAILS: max_fails_q <= pwdata[7:0];
				REG_WINDOW_US: window_us_q <= pwdata;
				REG_BLOCK_US:  block_us_q  <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_MAX_FAILS: prdata = {24'b0, max_fails_q};
			REG_WINDOW_US: prdata = window_us_q;
			REG_BLOCK_US:  prdata = block_us_q;
			default:       prdata = '0;
		endcase
	end

	assign chain_valid[0] = scan_start;
	assign chain_rec[0]   = '0;
	assign chain_found[0] = '0;
	assign chain_empty[0] = '0;
	assign chain_old[0]   = '0;

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		afrl_cell #(
			.ENTRIES  (ENTRIES),
			.CELL_IDX (i)
		) u_cell (
			.clk           (clk),
			.arst_n        (arst_n),
			.key           (scan_key),
			.in_valid      (chain_valid[i]),
			.in_rec        (chain_rec[i]),
			.in_found_idx  (chain_found[i]),
			.in_empty_idx  (chain_empty[i]),
			.in_old_idx    (chain_old[i]),
			.out_valid     (chain_valid[i+1]),
			.out_rec       (chain_rec[i+1]),
			.out_found_idx (chain_found[i+1]),
			.out_empty_idx (chain_empty[i+1]),
			.out_old_idx   (chain_old[i+1]),
			.wr            (wr),
			.wr_idx        (wr_idx)
		);
	end

	afrl_ctrl #(
		.ENTRIES (ENTRIES)
	) u_ctrl (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.mode            (s_tuser),
		.addr            (s_tdata[31:0]),
		.now             (s_tdata[94:32]),
		.max_fails       (max_fails_q),
		.window_us       (window_us_q),
		.block_us        (block_us_q),
		.scan_start      (scan_start),
		.scan_key        (scan_key),
		.scan_done       (chain_valid[ENTRIES]),
		.scan_rec        (chain_rec[ENTRIES]),
		.found_idx       (chain_found[ENTRIES]),
		.empty_idx       (chain_empty[ENTRIES]),
		.old_idx         (chain_old[ENTRIES]),
		.wr              (wr),
		.wr_idx          (wr_idx),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.blocked         (blocked),
		.block_started   (block_started),
		.fails_in_window (fails_in_window),
		.slot_used       (slot_used)
	);

	assign m_tdata = {2'b00, 4'(slot_used), fails_in_window, block_started, blocked};

endmodule

### bench/tb.sv
// self-checking bench for the per-source authentication failure rate limiter
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import afrl_pkg::*;

	localparam int ENTRIES = 16;
	localparam int POOL_MAX = 24;
	localparam logic [1:0] MODE_CHECK     = 2'd0;
	localparam logic [1:0] MODE_ALT_CHECK = 2'd3;
	localparam key_t SRC_A   = 32'h0A00_0001;
	localparam key_t SRC_B   = 32'h8000_0003;
	localparam key_t SRC_TOP = 32'hFFFF_FFFF;

	typedef struct packed {
		logic       blocked;
		logic       started;
		cnt_t       fails;
		logic [3:0] slot;
	} verdict_t;

	typedef struct {
		logic [1:0] mode;
		key_t       addr;
		time_t      now;
		bit         typed;
		verdict_t   want;
	} probe_t;

	typedef struct {
		cnt_t        max_fails;
		logic [31:0] window_us;
		logic [31:0] block_us;
		int unsigned tick;
		int          pool_n;
		bit          hammer;
		int          beats;
		int          tx_idle;
		int          rx_idle;
		bit          squeeze;
	} phase_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [95:0] s_tdata;   // source_address[31:0], now_us[94:32], zero[95]
	logic [1:0]  s_tuser;   // mode[1:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;   // blocked[0], block_started[1], fails_in_window[9:2],
	                        // slot_used[13:10], zero[15:14]
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	auth_fail_rate_limiter_core #(.ENTRIES(ENTRIES)) dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// shadow of the source table and registers
	key_t        src_key [ENTRIES];
	time_t       win_start [ENTRIES];
	cnt_t        fail_cnt [ENTRIES];
	time_t       block_end [ENTRIES];
	cnt_t        cfg_max_fails;
	logic [31:0] cfg_window;
	logic [31:0] cfg_block;

	verdict_t verdict_q [$];
	verdict_t seen;
	verdict_t owed;
	key_t     pool [POOL_MAX];
	probe_t   probes [23];
	phase_t   phases [5];
	time_t    clock_us;

	int tx_idle;
	int rx_idle;
	int hold_asked;
	int hold_served;
	int hold_left;
	int mismatches;
	int beats_sent;
	int results_seen;
	int blocks_seen;
	int ceiling_seen;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("auth_fail_rate_limiter_core test failed");
		$finish;
	end

	function automatic verdict_t rate_limit_step(input logic [1:0] mode, input key_t addr,
			input time_t now);
		int i;
		int hit;
		int empty;
		int oldest;
		int s;
		longint gap;
		logic [63:0] end_time;
		verdict_t v;
		hit = -1;
		empty = -1;
		oldest = 0;
		for (i = 0; i < ENTRIES; i++) begin
			if (hit < 0) begin
				if (src_key[i] == addr) begin
					hit = i;
				end else begin
					if (src_key[i] == '0 && empty < 0)
						empty = i;
					if (win_start[i] < win_start[oldest])
						oldest = i;
				end
			end
		end
		if (hit >= 0) begin
			s = hit;
		end else begin
			s = (empty >= 0) ? empty : oldest;
			src_key[s] = addr;
			win_start[s] = now;
			fail_cnt[s] = '0;
			block_end[s] = '0;
		end
		v = '0;
		v.slot = s[3:0];
		if (mode == MODE_FAIL) begin
			gap = longint'({1'b0, now}) - longint'({1'b0, win_start[s]});
			if (gap > longint'({32'b0, cfg_window})) begin
				win_start[s] = now;
				fail_cnt[s] = '0;
			end
			if (fail_cnt[s] != CNT_MAX)
				fail_cnt[s] = fail_cnt[s] + 1'b1;
			if (fail_cnt[s] >= cfg_max_fails) begin
				end_time = {1'b0, now} + {32'b0, cfg_block};
				block_end[s] = (end_time > {1'b0, TIME_MAX}) ? TIME_MAX : end_time[62:0];
				v.started = 1'b1;
			end
		end else if (mode == MODE_SUCCESS) begin
			fail_cnt[s] = '0;
			block_end[s] = '0;
		end
		v.blocked = block_end[s] > now;
		v.fails = fail_cnt[s];
		return v;
	endfunction

	function automatic verdict_t v_of(input bit b, input bit st, input int f, input int sl);
		verdict_t v;
		v.blocked = b;
		v.started = st;
		v.fails = f[7:0];
		v.slot = sl[3:0];
		return v;
	endfunction

	task automatic note_mismatch(input string what, input verdict_t want, input verdict_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("%s: expected blocked %0b started %0b fails %0d slot %0d, got %0b %0b %0d %0d",
				what, want.blocked, want.started, want.fails, want.slot,
				got.blocked, got.started, got.fails, got.slot);
	endtask

	task automatic send_beat(input logic [1:0] mode, input key_t addr, input time_t now,
			input bit typed, input verdict_t want);
		verdict_t v;
		@(negedge clk);
		while ($urandom_range(0, 99) < tx_idle) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= mode;
		s_tdata <= {1'b0, now, addr};
		do @(posedge clk); while (!s_tready);
		v = rate_limit_step(mode, addr, now);
		verdict_q.push_back(typed ? want : v);
		beats_sent++;
	endtask

	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (verdict_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
		logic [31:0] held;
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_MAX_FAILS: cfg_max_fails = val[7:0];
			REG_WINDOW_US: cfg_window = val;
			REG_BLOCK_US:  cfg_block = val;
			default: ;
		endcase
		held = (idx == REG_MAX_FAILS) ? {24'b0, val[7:0]} : val;
		// read back the same register
		@(negedge clk);
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== held) begin
			mismatches++;
			if (mismatches <= 10)
				$display("register at 0x%0h: expected 0x%08h, read 0x%08h",
					{idx, 2'b00}, held, prdata);
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic run_phase(input phase_t ph);
		logic [1:0]  mode;
		key_t        addr;
		time_t       now;
		logic [63:0] raw;
		int          r;
		int          k;
		drain();
		cfg_write(REG_MAX_FAILS, {24'b0, ph.max_fails});
		cfg_write(REG_WINDOW_US, ph.window_us);
		cfg_write(REG_BLOCK_US, ph.block_us);
		for (k = 0; k < POOL_MAX; k++) begin
			pool[k] = $urandom;
			if (pool[k] == '0)
				pool[k] = 32'd1;
		end
		tx_idle = ph.tx_idle;
		rx_idle = ph.rx_idle;
		if (ph.squeeze)
			hold_asked++;
		repeat (ph.beats) begin
			r = $urandom_range(0, 99);
			if (ph.hammer)
				mode = (r < 95) ? MODE_FAIL : MODE_CHECK;
			else if (r < 50)
				mode = MODE_FAIL;
			else if (r < 75)
				mode = MODE_CHECK;
			else if (r < 90)
				mode = MODE_SUCCESS;
			else
				mode = MODE_ALT_CHECK;
			r = $urandom_range(0, 99);
			if (ph.hammer || r < 90)
				addr = pool[$urandom_range(0, ph.pool_n - 1)];
			else if (r < 96)
				addr = $urandom;
			else
				addr = '0;
			r = $urandom_range(0, 99);
			if (!ph.hammer && r >= 97) begin
				raw = {$urandom, $urandom};
				now = raw[62:0];
			end else begin
				clock_us = clock_us + time_t'($urandom_range(0, ph.tick));
				now = clock_us;
			end
			send_beat(mode, addr, now, 1'b0, '0);
		end
	endtask

	// result side: random stalls plus an occasional long hold-off
	always @(negedge clk) begin
		if (hold_left == 0 && hold_served != hold_asked) begin
			hold_left = 400;
			hold_served++;
		end
		if (hold_left != 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= rx_idle);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			seen.blocked = m_tdata[0];
			seen.started = m_tdata[1];
			seen.fails = m_tdata[9:2];
			seen.slot = m_tdata[13:10];
			results_seen++;
			if (seen.started === 1'b1)
				blocks_seen++;
			if (seen.fails === CNT_MAX)
				ceiling_seen++;
			if (verdict_q.size() == 0) begin
				note_mismatch("result beat with nothing pending", '0, seen);
			end else begin
				owed = verdict_q.pop_front();
				if (seen.blocked !== owed.blocked || seen.started !== owed.started ||
						seen.fails !== owed.fails || seen.slot !== owed.slot)
					note_mismatch("result mismatch", owed, seen);
			end
		end
	end

	initial begin
		int p;
		int i;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		for (i = 0; i < ENTRIES; i++) begin
			src_key[i] = '0;
			win_start[i] = '0;
			fail_cnt[i] = '0;
			block_end[i] = '0;
		end
		cfg_max_fails = MAX_FAILS_RST;
		cfg_window = WINDOW_US_RST;
		cfg_block = BLOCK_US_RST;
		clock_us = '0;
		tx_idle = 14;
		rx_idle = 45;

		probes[0]  = '{MODE_CHECK,     SRC_A,   63'd1000,        1'b1, v_of(0, 0, 0, 0)};
		probes[1]  = '{MODE_FAIL,      SRC_A,   63'd1000,        1'b1, v_of(0, 0, 1, 0)};
		probes[2]  = '{MODE_FAIL,      SRC_A,   63'd2000,        1'b1, v_of(0, 0, 2, 0)};
		probes[3]  = '{MODE_FAIL,      SRC_A,   63'd3000,        1'b1, v_of(0, 0, 3, 0)};
		probes[4]  = '{MODE_FAIL,      SRC_A,   63'd4000,        1'b1, v_of(0, 0, 4, 0)};
		probes[5]  = '{MODE_FAIL,      SRC_A,   63'd5000,        1'b1, v_of(1, 1, 5, 0)};
		probes[6]  = '{MODE_ALT_CHECK, SRC_A,   63'd6000,        1'b1, v_of(1, 0, 5, 0)};
		probes[7]  = '{MODE_SUCCESS,   SRC_A,   63'd7000,        1'b1, v_of(0, 0, 0, 0)};
		// address zero lands on the first empty slot without clearing it
		probes[8]  = '{MODE_CHECK,     '0,      63'd8000,        1'b1, v_of(0, 0, 0, 1)};
		probes[9]  = '{MODE_FAIL,      '0,      63'd9000,        1'b1, v_of(0, 0, 1, 1)};
		probes[10] = '{MODE_FAIL,      SRC_TOP, 63'd10000,       1'b1, v_of(0, 0, 1, 1)};
		// window edge: equal to the length keeps counting, one past restarts
		probes[11] = '{MODE_FAIL,      SRC_A,   63'd20000,       1'b1, v_of(0, 0, 1, 0)};
		probes[12] = '{MODE_FAIL,      SRC_A,   63'd60001000,    1'b1, v_of(0, 0, 2, 0)};
		probes[13] = '{MODE_FAIL,      SRC_A,   63'd60001001,    1'b1, v_of(0, 0, 1, 0)};
		probes[14] = '{MODE_FAIL,      SRC_A,   63'd5,           1'b1, v_of(0, 0, 2, 0)};
		// block end clamps at the top of the time range
		probes[15] = '{MODE_FAIL,      SRC_B,   TIME_MAX - 63'd10, 1'b1, v_of(0, 0, 1, 2)};
		probes[16] = '{MODE_FAIL,      SRC_B,   TIME_MAX - 63'd10, 1'b0, '0};
		probes[17] = '{MODE_FAIL,      SRC_B,   TIME_MAX - 63'd10, 1'b0, '0};
		probes[18] = '{MODE_FAIL,      SRC_B,   TIME_MAX - 63'd10, 1'b0, '0};
		probes[19] = '{MODE_FAIL,      SRC_B,   TIME_MAX - 63'd10, 1'b1, v_of(1, 1, 5, 2)};
		probes[20] = '{MODE_CHECK,     SRC_B,   TIME_MAX - 63'd1,  1'b1, v_of(1, 0, 5, 2)};
		probes[21] = '{MODE_CHECK,     SRC_B,   TIME_MAX,          1'b1, v_of(0, 0, 5, 2)};
		probes[22] = '{MODE_SUCCESS,   SRC_TOP, 63'd0,             1'b1, v_of(0, 0, 0, 1)};

		phases[0] = '{MAX_FAILS_RST, WINDOW_US_RST, BLOCK_US_RST, 2000000, 8, 1'b0, 500,
			14, 45, 1'b1};
		phases[1] = '{8'd1, 32'd1, 32'd1, 3, 24, 1'b0, 400, 14, 45, 1'b0};
		// long window and high limit so single sources run the count to its ceiling
		phases[2] = '{8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1000, 2, 1'b1, 600, 45, 14, 1'b0};
		phases[3] = '{8'd0, 32'd100, 32'd50, 40, 20, 1'b0, 200, 45, 14, 1'b0};
		phases[4] = '{8'd3, 32'd500, 32'd500, 200, 18, 1'b0, 200, 0, 0, 1'b1};

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (probes[i])
			send_beat(probes[i].mode, probes[i].addr, probes[i].now, probes[i].typed,
				probes[i].want);

		for (p = 0; p < 5; p++) begin
			if (p == 4) begin
				phases[4].max_fails = cnt_t'($urandom_range(1, 6));
				phases[4].window_us = $urandom_range(1, 2000);
				phases[4].block_us = $urandom_range(1, 2000);
				phases[4].tick = $urandom_range(1, 400);
			end
			run_phase(phases[p]);
		end

		drain();
		repeat (2 * ENTRIES + 10) @(posedge clk);
		$display("%0d beats sent and %0d results checked over the directed table and five random phases",
			beats_sent, results_seen);
		$display("%0d blocks started, %0d results at the failure count ceiling, %0d mismatches",
			blocks_seen, ceiling_seen, mismatches);
		if (mismatches == 0 && verdict_q.size() == 0)
			$display("auth_fail_rate_limiter_core test passed");
		else
			$display("auth_fail_rate_limiter_core test failed");
		$finish;
	end

endmodule
